// File: rtl/core/line_follower_pid_drive_unit_macros.svh
// Assertion macros for the line follower PID drive unit.
// Used by the top level; no other dependencies.
`ifndef LINE_FOLLOWER_PID_DRIVE_UNIT_MACROS_SVH
`define LINE_FOLLOWER_PID_DRIVE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LFP_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define LFP_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define LFP_ASSERT_IMP(label, clk, rst_n, a, c)
`define LFP_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/core/lfp_pkg.sv
// Shared constants and types for the line follower PID drive unit.
// No dependencies.
`timescale 1ns / 1ps
package lfp_pkg;
  localparam int ERR_W = 14;
  localparam int ACC_W = 48;
  // register indexes
  localparam logic [2:0] REG_GAIN_P = 3'd0;
  localparam logic [2:0] REG_GAIN_I = 3'd1;
  localparam logic [2:0] REG_GAIN_D = 3'd2;
  localparam logic [2:0] REG_GAIN_R = 3'd3;
  localparam logic [2:0] REG_BASE_L = 3'd4;
  localparam logic [2:0] REG_BASE_R = 3'd5;
  localparam logic [2:0] REG_MAX_SPD = 3'd6;
  localparam logic [2:0] REG_CENTER = 3'd7;
  // side codes
  localparam logic [1:0] SIDE_RIGHT = 2'd0;
  localparam logic [1:0] SIDE_LEFT = 2'd1;
  localparam logic [1:0] SIDE_CENTER = 2'd2;
  localparam logic [3:0] IDLE_SAT = 4'd15;

  // sequencer to MAC-unit control
  typedef struct packed {
    logic clear;
    logic load;
  } mac_ctl_t;

  // duty from signed speed; forward when fwd set
  function automatic logic [9:0] duty_of(input logic signed [7:0] s, input logic fwd);
    logic [7:0] mag;
    mag = s[7] ? 8'(-s) : 8'(s);
    if (s[7] == fwd) duty_of = 10'd0;
    else duty_of = 10'({2'b0, mag} * 10'd10);
  endfunction
endpackage

// File: rtl/core/lfp_mac.sv
// Shared signed multiply-accumulate unit, one product per cycle.
// Depends on lfp_pkg.
`timescale 1ns / 1ps
module lfp_mac (
  input  logic                          clk,
  input  lfp_pkg::mac_ctl_t             ctl,
  input  logic signed [17:0]            op_a,
  input  logic [23:0]                   op_b,
  output logic signed [lfp_pkg::ACC_W-1:0] acc
);
  import lfp_pkg::*;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, prod;
  logic signed [42:0]      prod_full;
  // 18 x 25 signed product, sign-extended to the accumulator width
  assign prod_full = op_a * $signed({1'b0, op_b});
  assign prod = ACC_W'(prod_full);
  // clear drops the old sum; load adds the product (both may be set)
  always_comb begin
    acc_nxt = (ctl.clear ? '0 : acc_r) + (ctl.load ? prod : '0);
  end
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end
  assign acc = acc_r;
endmodule

// File: rtl/core/line_follower_pid_drive_unit.sv
// Top level of the line follower PID drive unit: sequencer, history, APB regs.
// Depends on lfp_pkg, lfp_mac and the assertion macro header.
// Usage:
//   in_valid/in_ready carry one 5-bit sensor beat; out_valid/out_ready carry
//   one beat of four PWM duties, line position and the line-lost flag.
//   The APB port writes gains, base speeds, max speed and center position;
//   write it only while no beat is in work.
//   Processing: after a beat is accepted, the sequencer forms the lit-sensor
//   sum, position (shift or reciprocal multiply) and history push, runs the
//   shared multiply-accumulate unit for P, I and D, truncates the steering
//   term and forms the absolute-sum product, then clamps speeds and loads
//   the result register. A new beat is accepted only once the previous
//   result beat has been taken; in_ready is high only while the sequencer
//   is idle.
//   When the receiver stalls, the result register holds and in_ready stays
//   low until the result beat is taken.
//   Reset clears history, previous error, side, idle count and loads the
//   default register values; no clearing pass is needed.
`timescale 1ns / 1ps
`include "line_follower_pid_drive_unit_macros.svh"
module line_follower_pid_drive_unit #(
  parameter int HISTORY_DEPTH = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_sensor_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_left_forward_duty,
  output logic [9:0]  out_left_reverse_duty,
  output logic [9:0]  out_right_forward_duty,
  output logic [9:0]  out_right_reverse_duty,
  output logic [12:0] out_line_position,
  output logic        out_line_lost,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lfp_pkg::*;
  localparam logic [2:0] ST_IDLE = 3'd0, ST_POS = 3'd1, ST_MAC = 3'd2,
                         ST_MS = 3'd3, ST_FIN = 3'd4, ST_OUT = 3'd5;
  localparam int HS_W = ERR_W + $clog2(HISTORY_DEPTH + 1);

  // configuration registers
  logic [23:0] gain_p_r, gain_i_r, gain_d_r, gain_r_r;
  logic [6:0]  base_l_r, base_r_r, max_spd_r;
  logic [12:0] center_r;
  logic        wr_en;
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= 24'd131; gain_i_r <= 24'd66; gain_d_r <= 24'd983040;
      gain_r_r <= 24'd0; base_l_r <= 7'd92; base_r_r <= 7'd92;
      max_spd_r <= 7'd100; center_r <= 13'd3000;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_GAIN_P:  gain_p_r <= pwdata[23:0];
        REG_GAIN_I:  gain_i_r <= pwdata[23:0];
        REG_GAIN_D:  gain_d_r <= pwdata[23:0];
        REG_GAIN_R:  gain_r_r <= pwdata[23:0];
        REG_BASE_L:  base_l_r <= pwdata[6:0];
        REG_BASE_R:  base_r_r <= pwdata[6:0];
        REG_MAX_SPD: max_spd_r <= pwdata[6:0];
        REG_CENTER:  center_r <= pwdata[12:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[4:2])
      REG_GAIN_P:  prdata = {8'd0, gain_p_r};
      REG_GAIN_I:  prdata = {8'd0, gain_i_r};
      REG_GAIN_D:  prdata = {8'd0, gain_d_r};
      REG_GAIN_R:  prdata = {8'd0, gain_r_r};
      REG_BASE_L:  prdata = {25'd0, base_l_r};
      REG_BASE_R:  prdata = {25'd0, base_r_r};
      REG_MAX_SPD: prdata = {25'd0, max_spd_r};
      REG_CENTER:  prdata = {19'd0, center_r};
      default:     prdata = '0;
    endcase
  end

  // sequencer state and datapath registers
  logic [2:0]  st_r, st_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [4:0]  bits_r;
  logic [12:0] pos_r;
  logic        lost_r;
  logic signed [ERR_W-1:0] hist_r [HISTORY_DEPTH];
  logic signed [ERR_W-1:0] prev_r;
  logic [1:0]  side_r, side_nxt;
  logic [3:0]  idle_r;
  logic signed [ACC_W-1:0] ms_r;
  logic signed [HS_W-1:0] isum, rsum;
  logic signed [ERR_W-1:0] err, err_new;
  logic signed [ACC_W-1:0] acc;
  mac_ctl_t    mac_ctl;
  logic signed [17:0] op_a;
  logic [23:0] op_b;

  // weighted sum, count and highest lit side
  logic [13:0] wsum;
  logic [2:0]  wcnt;
  always_comb begin
    wsum = '0; wcnt = '0; side_nxt = side_r;
    for (int k = 0; k < 5; k++) begin
      if (bits_r[k]) begin
        wsum = wsum + 14'(1000 * (k + 1));
        wcnt = wcnt + 3'd1;
        side_nxt = (k < 2) ? SIDE_LEFT : ((k == 2) ? SIDE_CENTER : SIDE_RIGHT);
      end
    end
  end

  // position = wsum / wcnt; shifts for 1, 2, 4, reciprocal for 3 and 5
  logic [12:0] pos;
  logic [29:0] recip_p;
  always_comb begin
    case (wcnt)
      3'd3:    recip_p = {16'd0, wsum} * 30'd21846;
      3'd5:    recip_p = {16'd0, wsum} * 30'd13108;
      default: recip_p = '0;
    endcase
    case (wcnt)
      3'd1:       pos = wsum[12:0];
      3'd2:       pos = wsum[13:1];
      3'd4:       pos = {1'b0, wsum[13:2]};
      3'd3, 3'd5: pos = recip_p[28:16];
      default:    pos = 13'd0;
    endcase
  end
  assign err_new = $signed({1'b0, center_r}) - $signed({1'b0, pos});

  // signed and absolute history sums
  always_comb begin
    isum = '0; rsum = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      isum = isum + HS_W'(hist_r[k]);
      rsum = rsum + (hist_r[k][ERR_W-1] ? -HS_W'(hist_r[k]) : HS_W'(hist_r[k]));
    end
  end
  assign err = hist_r[0];

  // MAC operands: P, I, D in the MAC steps, absolute-sum term after
  logic signed [ERR_W:0] dlt;
  assign dlt = (ERR_W+1)'(err) - (ERR_W+1)'(prev_r);
  always_comb begin
    op_a = '0; op_b = '0;
    if (st_r == ST_MS) begin
      op_a = 18'(rsum); op_b = gain_r_r;
    end else begin
      case (cnt_r)
        2'd0:    begin op_a = 18'(err);  op_b = gain_p_r; end
        2'd1:    begin op_a = 18'(isum); op_b = gain_i_r; end
        default: begin op_a = 18'(dlt);  op_b = gain_d_r; end
      endcase
    end
  end
  assign mac_ctl.clear = (st_r == ST_POS) || (st_r == ST_MS);
  assign mac_ctl.load  = (st_r == ST_MAC) || (st_r == ST_MS);

  lfp_mac u_mac (.clk(clk), .ctl(mac_ctl), .op_a(op_a), .op_b(op_b), .acc(acc));

  // speed math; accumulator holds the absolute-sum term in ST_FIN
  logic signed [ACC_W-1:0] lt, rt, lfix, rfix;
  logic signed [7:0]  lspd, rspd, hi;
  logic [6:0] mxc;
  assign mxc = (max_spd_r > 7'd100) ? 7'd100 : max_spd_r;
  assign hi = $signed({1'b0, mxc});
  function automatic logic signed [7:0] clampv(input logic signed [47:0] v,
                                              input logic signed [7:0] h);
    if (v > 48'(h)) clampv = h;
    else if (v < -48'sd100) clampv = -8'sd100;
    else clampv = 8'(v);
  endfunction
  always_comb begin
    lt = $signed({41'd0, base_l_r}) + ms_r;
    rt = $signed({41'd0, base_r_r}) - ms_r;
    lfix = ((lt <<< 16) - acc) / 48'sd65536;
    rfix = ((rt <<< 16) - acc) / 48'sd65536;
    lspd = clampv(lfix, hi);
    rspd = clampv(rfix, hi);
    // line lost: fixed search turn from last side and idle count
    if (lost_r) begin
      if (idle_r < IDLE_SAT) begin
        if (side_r == SIDE_LEFT)        begin lspd = 8'sd100; rspd = -8'sd20; end
        else if (side_r == SIDE_CENTER) begin lspd = 8'sd100; rspd = 8'sd100; end
        else                            begin lspd = -8'sd20; rspd = 8'sd100; end
      end else begin
        if (side_r == SIDE_LEFT)        begin lspd = 8'sd70;  rspd = -8'sd53; end
        else if (side_r == SIDE_CENTER) begin lspd = 8'sd100; rspd = 8'sd100; end
        else                            begin lspd = -8'sd53; rspd = 8'sd70; end
      end
    end
  end

  // control sequencer
  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r;
    case (st_r)
      ST_IDLE: if (in_valid) st_nxt = ST_POS;
      ST_POS: begin st_nxt = ST_MAC; cnt_nxt = '0; end
      ST_MAC: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd2) st_nxt = ST_MS;
      end
      ST_MS:   st_nxt = ST_FIN;
      ST_FIN:  st_nxt = ST_OUT;
      ST_OUT:  if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end
  assign in_ready = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; prev_r <= '0; side_r <= SIDE_RIGHT;
      idle_r <= '0; bits_r <= '0; pos_r <= '0; lost_r <= 1'b0; ms_r <= '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) hist_r[k] <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt;
      case (st_r)
        ST_IDLE: if (in_valid) bits_r <= in_sensor_bits;
        ST_POS: begin
          pos_r  <= pos;
          lost_r <= (wcnt == 3'd0);
          side_r <= side_nxt;
          idle_r <= (wcnt != 3'd0) ? 4'd0 :
                    ((idle_r < IDLE_SAT) ? idle_r + 4'd1 : idle_r);
          for (int k = HISTORY_DEPTH - 1; k > 0; k--) hist_r[k] <= hist_r[k-1];
          hist_r[0] <= err_new;
        end
        ST_MAC: if (cnt_r == 2'd2) prev_r <= err;
        ST_MS:  ms_r <= acc / 48'sd65536;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (st_r == ST_FIN) begin
      out_left_forward_duty  <= duty_of(lspd, 1'b1);
      out_left_reverse_duty  <= duty_of(lspd, 1'b0);
      out_right_forward_duty <= duty_of(rspd, 1'b1);
      out_right_reverse_duty <= duty_of(rspd, 1'b0);
      out_line_position      <= pos_r;
      out_line_lost          <= lost_r;
    end
  end

  `LFP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `LFP_ASSERT_IMP(a_excl, clk, rst_n, 1'b1, !(in_ready && out_valid))
  `LFP_ASSERT_IMP(a_idle_sat, clk, rst_n, 1'b1, idle_r <= IDLE_SAT)
endmodule
